// ----- sv/lenient_base64_decoder_macros.svh -----
// assertion macros for the lenient base64 decoder checker
// expects signals clk and rst in the scope of use
`ifndef LENIENT_BASE64_DECODER_MACROS_SVH
`define LENIENT_BASE64_DECODER_MACROS_SVH

// condition that must hold on every cycle out of reset
`define LB64_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent on one cycle implies consequent on the next
`define LB64_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/lb64_pkg.sv -----
// shared types, constants and the character map of the lenient base64 decoder
// no dependencies
`timescale 1ns / 1ps

package lb64_pkg;

  localparam int SEXTET_W = 6;
  localparam int BYTE_W   = 8;
  localparam int GRP_BYTES = 3;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;
  localparam logic [7:0] CH_DIGIT_0 = 8'h30;
  localparam logic [7:0] CH_DIGIT_9 = 8'h39;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_SLASH   = 8'h2F;

  localparam logic [7:0] LOWER_BASE = 8'd26;
  localparam logic [7:0] DIGIT_BASE = 8'd52;
  localparam logic [SEXTET_W-1:0] SEX_PLUS  = 6'd62;
  localparam logic [SEXTET_W-1:0] SEX_SLASH = 6'd63;

  // input kinds carried on tuser
  localparam logic ACT_CHAR  = 1'b0;
  localparam logic ACT_FLUSH = 1'b1;

  // fill levels of the sextet store
  localparam logic [1:0] FILL_TWO   = 2'd2;
  localparam logic [1:0] FILL_THREE = 2'd3;

  // one queued group: up to three bytes and how many result words they make
  typedef struct packed {
    logic [GRP_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [1:0]                       nres;
    logic                             byte_valid;
    logic                             mend;
  } grp_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  typedef struct packed {
    logic                hit;
    logic [SEXTET_W-1:0] sextet;
  } map_t;

  function automatic map_t map_char(input logic [7:0] c);
    map_t        m;
    logic [7:0]  d;
    m.hit    = 1'b1;
    m.sextet = '0;
    d        = '0;
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
      d = c - CH_UPPER_A;
    end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
      d = c - CH_LOWER_A + LOWER_BASE;
    end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
      d = c - CH_DIGIT_0 + DIGIT_BASE;
    end else if (c == CH_PLUS) begin
      d = {2'b00, SEX_PLUS};
    end else if (c == CH_SLASH) begin
      d = {2'b00, SEX_SLASH};
    end else begin
      m.hit = 1'b0;
    end
    m.sextet = d[SEXTET_W-1:0];
    return m;
  endfunction

endpackage

// ----- sv/lb64_front.sv -----
// front end: takes characters, maps them to sextets and packs groups into bytes
// depends on lb64_pkg
`timescale 1ns / 1ps

module lb64_front import lb64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // char_code
  input  logic       s_axis_tuser,   // action
  output logic       push,
  output grp_t       push_grp,
  input  fifo_stat_t stat
);

  logic [2:0][SEXTET_W-1:0] store;
  logic [2:0][SEXTET_W-1:0] store_next;
  logic [1:0]               fill;
  logic [1:0]               fill_next;
  map_t                     m;
  logic                     acc;
  logic [BYTE_W-1:0]        b0, b1, b2;

  assign s_axis_tready = !stat.full;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign m   = map_char(s_axis_tdata);

  assign b0 = {store[0], store[1][5:4]};
  assign b1 = {store[1][3:0], store[2][5:2]};
  assign b2 = {store[2][1:0], m.sextet};

  always_comb begin
    store_next = store;
    fill_next  = fill;
    push       = 1'b0;
    push_grp   = '0;
    if (acc) begin
      if (s_axis_tuser == ACT_FLUSH) begin
        push          = 1'b1;
        push_grp.mend = 1'b1;
        fill_next     = '0;
        store_next    = '0;
        if (fill == FILL_THREE) begin
          push_grp.bytes[0]   = b0;
          push_grp.bytes[1]   = b1;
          push_grp.nres       = 2'd2;
          push_grp.byte_valid = 1'b1;
        end else if (fill == FILL_TWO) begin
          push_grp.bytes[0]   = b0;
          push_grp.nres       = 2'd1;
          push_grp.byte_valid = 1'b1;
        end else begin
          // nothing decodable: a single empty end word
          push_grp.nres = 2'd1;
        end
      end else if (m.hit) begin
        if (fill == FILL_THREE) begin
          push                = 1'b1;
          push_grp.bytes[0]   = b0;
          push_grp.bytes[1]   = b1;
          push_grp.bytes[2]   = b2;
          push_grp.nres       = 2'd3;
          push_grp.byte_valid = 1'b1;
          fill_next           = '0;
          store_next          = '0;
        end else begin
          store_next[fill] = m.sextet;
          fill_next        = fill + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      store <= '0;
      fill  <= '0;
    end else begin
      store <= store_next;
      fill  <= fill_next;
    end
  end

endmodule

// ----- sv/lb64_fifo.sv -----
// small group queue between the front and back ends
// depends on lb64_pkg
`timescale 1ns / 1ps

module lb64_fifo import lb64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  grp_t       din,
  input  logic       pop,
  output grp_t       dout,
  output fifo_stat_t stat
);

  grp_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr;
  logic [FIFO_AW-1:0] rd_ptr;
  logic [FIFO_AW:0]   count;
  logic               do_push;
  logic               do_pop;

  assign stat.full  = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign stat.empty = (count == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign dout       = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/lb64_back.sv -----
// back end: unpacks queued groups into one result word per cycle while
// m_axis does not stall; depends on lb64_pkg
`timescale 1ns / 1ps

module lb64_back import lb64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  grp_t       head,
  input  fifo_stat_t stat,
  output logic       pop,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // out_byte
  output logic [1:0] m_axis_tuser,   // byte_valid, message_end
  output logic       m_axis_tlast    // last_in_run
);

  logic [1:0] idx;
  logic       load;
  logic       last;

  // output register takes a new word whenever it is empty or being drained
  assign load = !m_axis_tvalid || m_axis_tready;
  assign last = (idx == head.nres - 2'd1);
  assign pop  = load && !stat.empty && last;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
      idx           <= '0;
    end else if (load) begin
      m_axis_tvalid <= !stat.empty;
      if (!stat.empty) begin
        idx <= last ? 2'd0 : idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !stat.empty) begin
      m_axis_tdata <= head.bytes[idx];
      m_axis_tuser <= {head.mend && last, head.byte_valid};
      m_axis_tlast <= last;
    end
  end

endmodule

// ----- sv/lenient_base64_decoder.sv -----
// lenient base64 decoder top level: front end, group queue, back end
// depends on lb64_pkg, lb64_front, lb64_fifo, lb64_back
//
//   port group  dir  tdata       tuser                      tlast
//   s_axis      in   char_code   action                     -
//   m_axis      out  out_byte    byte_valid, message_end    last_in_run
//
// one character or end item accepted per cycle while the group queue has room
// a group leaves the output register as one to three words, one per unstalled cycle
// a completed group enters the queue, then its first word the output register
// rst is synchronous and clears the sextet store, queue pointers and output valid
// a stalled m_axis fills the four-entry queue, then s_axis_tready drops
`timescale 1ns / 1ps

module lenient_base64_decoder import lb64_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] char_code
  input  logic       s_axis_tuser,   // [0] action
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] message_end
  output logic       m_axis_tlast
);

  logic       push;
  grp_t       push_grp;
  logic       pop;
  grp_t       head;
  fifo_stat_t stat;

  lb64_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .push          (push),
    .push_grp      (push_grp),
    .stat          (stat)
  );

  lb64_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .din  (push_grp),
    .pop  (pop),
    .dout (head),
    .stat (stat)
  );

  lb64_back u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .stat          (stat),
    .pop           (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ----- sv/lb64_checker.sv -----
// port-level checks for the lenient base64 decoder, bound to the top level
// depends on lenient_base64_decoder_macros.svh
`timescale 1ns / 1ps
`include "lenient_base64_decoder_macros.svh"

module lb64_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic        m_stall;
  logic [10:0] m_word;
  logic        m_end;
  logic        m_nobyte;
  logic        m_empty_ok;
  logic        m_mid;

  assign m_stall    = m_axis_tvalid && !m_axis_tready;
  assign m_word     = {m_axis_tdata, m_axis_tuser, m_axis_tlast};
  assign m_end      = m_axis_tvalid && m_axis_tuser[1];
  assign m_nobyte   = m_axis_tvalid && !m_axis_tuser[0];
  assign m_empty_ok = m_axis_tuser[1] && (m_axis_tdata == 8'h00);
  // a word taken that is not the last of its run
  assign m_mid      = m_axis_tvalid && m_axis_tready && !m_axis_tlast;

  `LB64_ASSERT_NEXT(a_out_hold, m_stall, m_axis_tvalid, "m_axis word dropped while stalled")
  `LB64_ASSERT_NEXT(a_out_stable, m_stall, $stable(m_word), "m_axis word changed in stall")
  `LB64_ASSERT_ALWAYS(a_end_is_last, !m_end || m_axis_tlast, "message end word without last_in_run")
  `LB64_ASSERT_ALWAYS(a_empty_word, !m_nobyte || m_empty_ok, "word without a byte is not a clean end")
  `LB64_ASSERT_NEXT(a_run_continues, m_mid, m_axis_tvalid && m_axis_tuser[0], "byte run broken")

endmodule

bind lenient_base64_decoder lb64_checker u_lb64_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

// ----- dv/testbench.sv -----
// self-checking bench for lenient_base64_decoder: random and directed base64 text
// checked word by word against a built-in decoder model; needs lb64_pkg and the rtl
`timescale 1ns / 1ps

module testbench;
  import lb64_pkg::*;

  typedef struct packed {
    logic       action;
    logic [7:0] code;
  } text_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last_in_run;
    logic       message_end;
  } dec_word_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;
  logic       s_axis_tuser = ACT_CHAR;
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic       m_axis_tlast;

  lenient_base64_decoder u_dut (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  text_item_t pending_text[$];
  dec_word_t  expected_words[$];
  text_item_t next_text;
  logic [5:0] held_sextets [3];
  logic [1:0] held_count = 2'd0;
  int         mismatch_count = 0;
  int         fed_items = 0;
  bit         text_on_bus = 1'b0;
  bit         src_quiet = 1'b0;
  bit         sink_quiet = 1'b0;
  bit         hold_req = 1'b0;
  int         src_gap = 0;
  int         sink_gap = 0;
  int         hold_left = 0;

  initial begin
    held_sextets[0] = '0;
    held_sextets[1] = '0;
    held_sextets[2] = '0;
  end

  // bit 6 set when the byte is an alphabet character
  function automatic logic [6:0] sextet_of(input logic [7:0] c);
    if (c >= CH_UPPER_A && c <= CH_UPPER_Z) return {1'b1, 6'(c - CH_UPPER_A)};
    if (c >= CH_LOWER_A && c <= CH_LOWER_Z) return {1'b1, 6'(c - CH_LOWER_A + LOWER_BASE)};
    if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) return {1'b1, 6'(c - CH_DIGIT_0 + DIGIT_BASE)};
    if (c == CH_PLUS) return {1'b1, SEX_PLUS};
    if (c == CH_SLASH) return {1'b1, SEX_SLASH};
    return 7'd0;
  endfunction

  function automatic dec_word_t word_of(input logic [7:0] b, input logic v, input logic l,
                                        input logic m);
    dec_word_t w;
    w.out_byte    = b;
    w.byte_valid  = v;
    w.last_in_run = l;
    w.message_end = m;
    return w;
  endfunction

  task automatic expect_word(input dec_word_t w);
    expected_words.insert(expected_words.size(), w);
  endtask

  task automatic queue_text(input text_item_t t);
    pending_text.insert(pending_text.size(), t);
  endtask

  task automatic clear_group();
    held_sextets[0] = '0;
    held_sextets[1] = '0;
    held_sextets[2] = '0;
    held_count      = 2'd0;
  endtask

  // decoder model: updates the sextet store and queues the words this item causes
  task automatic decode_text(input logic action, input logic [7:0] code);
    logic [6:0] sx;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    b0 = {held_sextets[0], held_sextets[1][5:4]};
    b1 = {held_sextets[1][3:0], held_sextets[2][5:2]};
    if (action == ACT_FLUSH) begin
      if (held_count == FILL_THREE) begin
        expect_word(word_of(b0, 1'b1, 1'b0, 1'b0));
        expect_word(word_of(b1, 1'b1, 1'b1, 1'b1));
      end else if (held_count == FILL_TWO) begin
        expect_word(word_of(b0, 1'b1, 1'b1, 1'b1));
      end else begin
        // nothing or a lone sextet: an empty end marker
        expect_word(word_of(8'h00, 1'b0, 1'b1, 1'b1));
      end
      clear_group();
    end else begin
      sx = sextet_of(code);
      if (sx[6]) begin
        if (held_count != FILL_THREE) begin
          held_sextets[held_count] = sx[5:0];
          held_count               = held_count + 2'd1;
        end else begin
          b2 = {held_sextets[2][1:0], sx[5:0]};
          expect_word(word_of(b0, 1'b1, 1'b0, 1'b0));
          expect_word(word_of(b1, 1'b1, 1'b0, 1'b0));
          expect_word(word_of(b2, 1'b1, 1'b1, 1'b0));
          clear_group();
        end
      end
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns mismatch on %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  task automatic check_word(input dec_word_t got);
    dec_word_t want;
    if (expected_words.size() == 0) begin
      report_mismatch("word with nothing pending", got, 0);
    end else begin
      want = expected_words.pop_front();
      if (got.out_byte !== want.out_byte)
        report_mismatch("out_byte", got.out_byte, want.out_byte);
      if (got.byte_valid !== want.byte_valid)
        report_mismatch("byte_valid", got.byte_valid, want.byte_valid);
      if (got.last_in_run !== want.last_in_run)
        report_mismatch("last_in_run", got.last_in_run, want.last_in_run);
      if (got.message_end !== want.message_end)
        report_mismatch("message_end", got.message_end, want.message_end);
    end
  endtask

  // monitor: output words are checked before the input word of the same edge is modeled
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready)
        check_word(word_of(m_axis_tdata, m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]));
      if (s_axis_tvalid && s_axis_tready) begin
        decode_text(s_axis_tuser, s_axis_tdata);
        text_on_bus = 1'b0;
      end
    end
  end

  // text driver
  always @(negedge clk) begin
    if (!rst && !text_on_bus) begin
      if (src_gap > 0) begin
        src_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_text.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!src_quiet && $urandom_range(0, 7) == 0) begin
        src_gap = $urandom_range(0, 14);
        s_axis_tvalid <= 1'b0;
      end else begin
        next_text = pending_text.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_text.action;
        s_axis_tdata  <= next_text.code;
        text_on_bus   = 1'b1;
      end
    end
  end

  // byte sink, with an occasional long hold-off to back up the group queue
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 80;
      hold_req  = 1'b0;
    end
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else if (sink_gap > 0) begin
      sink_gap--;
      m_axis_tready <= 1'b0;
    end else if (!sink_quiet && $urandom_range(0, 9) == 0) begin
      sink_gap = $urandom_range(0, 14);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic queue_char(input logic [7:0] code);
    queue_text(text_item_t'{action: ACT_CHAR, code: code});
    fed_items++;
  endtask

  task automatic queue_flush();
    queue_text(text_item_t'{action: ACT_FLUSH, code: 8'($urandom_range(0, 255))});
    fed_items++;
  endtask

  function automatic logic [7:0] pick_text_char();
    int idx;
    idx = $urandom_range(0, 63);
    if (idx < 26) return CH_UPPER_A + 8'(idx);
    if (idx < 52) return CH_LOWER_A + 8'(idx - 26);
    if (idx < 62) return CH_DIGIT_0 + 8'(idx - 52);
    return (idx == 62) ? CH_PLUS : CH_SLASH;
  endfunction

  function automatic logic [7:0] pick_filler();
    logic [7:0] c;
    case ($urandom_range(0, 4))
      0: c = 8'h3D;  // pad
      1: c = 8'h20;
      2: c = 8'h0A;
      3: c = 8'h0D;
      default: begin
        c = 8'($urandom_range(0, 255));
        while (sextet_of(c) != 7'd0) c = 8'($urandom_range(0, 255));
      end
    endcase
    return c;
  endfunction

  // mostly well-formed messages with stray filler, now and then raw garbage
  task automatic queue_message(input int max_groups);
    int nchars;
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(3, 10)) queue_char(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1) == 0) queue_flush();
    end else begin
      nchars = 4 * $urandom_range(0, max_groups) + $urandom_range(0, 3);
      repeat (nchars) begin
        if ($urandom_range(0, 5) == 0) queue_char(pick_filler());
        queue_char(pick_text_char());
      end
      if ($urandom_range(0, 3) == 0) queue_char(pick_filler());
      // a missing end item lets the next message run on from here
      if ($urandom_range(0, 9) != 0) queue_flush();
    end
  endtask

  task automatic wait_drained();
    while (pending_text.size() != 0 || text_on_bus) @(negedge clk);
    while (expected_words.size() != 0) @(negedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // alphabet edges mixed with skipped bytes, then every fill level at the end item
    queue_char(CH_UPPER_A);
    queue_char(8'h00);
    queue_char(CH_UPPER_Z);
    queue_char(8'h3D);
    queue_char(CH_LOWER_A);
    queue_char(8'hFF);
    queue_char(CH_LOWER_Z);
    queue_char(CH_DIGIT_0);
    queue_char(CH_DIGIT_9);
    queue_char(CH_PLUS);
    queue_char(CH_SLASH);
    queue_flush();
    queue_char(8'h40);
    queue_char(CH_SLASH);
    queue_flush();
    queue_char(8'h51);
    queue_char(8'h7B);
    queue_char(CH_LOWER_Z);
    queue_flush();
    queue_char(CH_SLASH);
    queue_char(8'h3A);
    queue_char(CH_SLASH);
    queue_char(CH_SLASH);
    queue_flush();
    queue_flush();
    wait_drained();

    while (fed_items < 140) queue_message(4);
    wait_drained();

    // back-to-back groups into a stalled sink
    src_quiet = 1'b1;
    hold_req  = 1'b1;
    repeat (16) repeat (4) queue_char(pick_text_char());
    queue_flush();
    wait_drained();
    src_quiet = 1'b0;

    while (fed_items < 240) queue_message(4);
    wait_drained();

    src_quiet  = 1'b1;
    sink_quiet = 1'b1;
    while (fed_items < 280) queue_message(3);
    wait_drained();
    repeat (20) @(negedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/lb64_pkg.sv
sv/lb64_front.sv
sv/lb64_fifo.sv
sv/lb64_back.sv
sv/lenient_base64_decoder.sv
sv/lb64_checker.sv
dv/testbench.sv
